// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ILBM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ilbm assertion failed");

// condition must never be seen outside reset
`define ILBM_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ilbm forbidden condition seen");

`endif

// ===== rtl/ilbm_pkg.sv =====
// ----------------------------------------------------------------------------
// ilbm_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package ilbm_pkg;

  localparam int unsigned MaxWidth  = 512;
  localparam int unsigned MaxPlanes = 8;
  localparam int unsigned BufBytes  = ((MaxWidth + 15) / 16) * 2 * MaxPlanes;
  localparam int unsigned BufAw     = $clog2(BufBytes);

  // register indexes
  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegPlanes = 2'd2;
  localparam logic [1:0] RegComp   = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic take;      // latch input item and decode it
    logic fill;      // write one byte into the row buffer
    logic check;     // evaluate row completion / body end
    logic rd;        // issue a row buffer read
    logic acc;       // merge read data into the group
    logic out_done;  // output group transferred
  } ilbm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rep_zero;
    logic emit_need;
    logic more_planes;
    logic last_group;
  } ilbm_sts_t;

endpackage

`default_nettype wire

// ===== rtl/ilbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilbm_ctrl
// sequencer: byte intake, buffer fill, row drain
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ilbm_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  input  wire ilbm_pkg::ilbm_sts_t sts_i,
  output ilbm_pkg::ilbm_cmd_t     cmd_o
);
  import ilbm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FILL  = 6'b000010,
    S_CHECK = 6'b000100,
    S_RD    = 6'b001000,
    S_ACC   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_FILL;
        end
      end
      S_FILL: begin
        if (sts_i.rep_zero) begin
          state_d = S_CHECK;
        end else begin
          cmd_o.fill = 1'b1;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.emit_need ? S_RD : S_IDLE;
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.more_planes ? S_RD : S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          cmd_o.out_done = 1'b1;
          state_d        = sts_i.last_group ? S_IDLE : S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  `ILBM_NEVER(a_no_in_while_out, clk_i, rst_ni, out_valid_o && !in_stall_o)
  `ILBM_ASSERT(a_last_group_idle, clk_i, rst_ni,
    (cmd_o.out_done && sts_i.last_group) |=> (state_q == S_IDLE))
  `ILBM_ASSERT(a_fill_needs_work, clk_i, rst_ni, cmd_o.fill |-> !sts_i.rep_zero)

endmodule

`default_nettype wire

// ===== rtl/ilbm_dp.sv =====
// ----------------------------------------------------------------------------
// ilbm_dp
// registers, byterun1 decode state, planar row buffer, group assembly
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ilbm_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ilbm_pkg::ilbm_cmd_t cmd_i,
  output ilbm_pkg::ilbm_sts_t      sts_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [31:0]         cfg_wdata_i,
  output logic [31:0]              cfg_rdata_o,
  input  wire logic [7:0]          body_byte_i,
  input  wire logic                last_byte_i,
  output logic [63:0]              pixel_group_o,
  output logic [3:0]               group_count_o,
  output logic                     row_end_o,
  output logic                     image_end_o
);
  import ilbm_pkg::*;

  logic [9:0]  width_q;
  logic [15:0] height_q;
  logic [3:0]  planes_q;
  logic        comp_q;

  logic [9:0]  fill_q;
  logic [7:0]  lit_q, run_q, rep_q;
  logic [15:0] row_q;
  logic        fin_q, end_q, last_q;
  logic [7:0]  byte_q;

  logic [7:0]        buf_mem [BufBytes];
  logic [7:0]        rdata_q;
  logic              zero_q;
  logic [BufAw-1:0]  addr_q;
  logic [5:0]        grp_q;
  logic [2:0]        pl_q;
  logic [63:0]       acc_q;

  // effective configuration
  logic [9:0]  w_eff;
  logic [3:0]  p_eff;
  logic [15:0] h_eff;
  logic [6:0]  stride;
  logic [6:0]  groups;
  logic [9:0]  row_len, left;
  logic [15:0] row_next;
  logic        full, done;
  logic [9:0]  rem;
  logic [3:0]  cnt;
  logic [8:0]  run_len;
  logic [8:0]  lit_len;

  always_comb begin
    w_eff = width_q;
    if (width_q == 10'd0) w_eff = 10'd1;
    else if (width_q > 10'(MaxWidth)) w_eff = 10'(MaxWidth);
    p_eff = planes_q;
    if (planes_q == 4'd0) p_eff = 4'd1;
    else if (planes_q > 4'(MaxPlanes)) p_eff = 4'(MaxPlanes);
    h_eff    = (height_q == 16'd0) ? 16'd1 : height_q;
  end

  logic [10:0] w_round;
  assign w_round  = 11'(w_eff) + 11'd15;
  assign stride   = {w_round[9:4], 1'b0};
  assign groups   = 7'((11'(w_eff) + 11'd7) >> 3);
  assign row_len  = 10'(stride) * 10'(p_eff);
  assign left     = row_len - fill_q;
  assign full     = (fill_q == row_len);
  assign row_next = row_q + 16'd1;
  assign done     = (row_next >= h_eff) || (row_next == 16'd0);
  assign rem      = w_eff - {1'b0, grp_q, 3'b000};
  assign cnt      = (rem > 10'd8) ? 4'd8 : rem[3:0];
  assign run_len  = 9'd257 - {1'b0, body_byte_i};
  assign lit_len  = {1'b0, body_byte_i} + 9'd1;

  assign sts_o.rep_zero    = (rep_q == 8'd0);
  assign sts_o.emit_need   = !fin_q && (full || (last_q && fill_q != 10'd0));
  assign sts_o.more_planes = ({1'b0, pl_q} + 4'd1) < p_eff;
  assign sts_o.last_group  = ({1'b0, grp_q} + 7'd1) == groups;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 10'd320;
      height_q <= 16'd200;
      planes_q <= 4'd5;
      comp_q   <= 1'b1;
      fill_q   <= '0;
      lit_q    <= '0;
      run_q    <= '0;
      rep_q    <= '0;
      row_q    <= '0;
      fin_q    <= 1'b0;
      end_q    <= 1'b0;
      last_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWidth:  width_q  <= cfg_wdata_i[9:0];
        RegHeight: height_q <= cfg_wdata_i[15:0];
        RegPlanes: planes_q <= cfg_wdata_i[3:0];
        RegComp:   comp_q   <= cfg_wdata_i[0];
        default:   comp_q   <= comp_q;
      endcase
      fill_q <= '0;
      lit_q  <= '0;
      run_q  <= '0;
      row_q  <= '0;
      fin_q  <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        last_q <= last_byte_i;
        if (fin_q) begin
          rep_q <= '0;
        end else if (!comp_q) begin
          rep_q <= 8'd1;
        end else if (lit_q != 8'd0) begin
          rep_q <= 8'd1;
          lit_q <= lit_q - 8'd1;
        end else if (run_q != 8'd0) begin
          rep_q <= run_q;
          run_q <= '0;
        end else begin
          rep_q <= '0;
          if (body_byte_i < 8'h80) begin
            lit_q <= (10'(lit_len) > left) ? left[7:0] : lit_len[7:0];
          end else if (body_byte_i > 8'h80) begin
            run_q <= (10'(run_len) > left) ? left[7:0] : run_len[7:0];
          end
        end
      end
      if (cmd_i.fill) begin
        fill_q <= fill_q + 10'd1;
        rep_q  <= rep_q - 8'd1;
      end
      if (cmd_i.check && !fin_q) begin
        if (full) begin
          row_q <= row_next;
          end_q <= done || last_q;
        end else if (last_q) begin
          end_q <= 1'b1;
          if (fill_q == 10'd0) begin
            fin_q <= 1'b1;
            lit_q <= '0;
            run_q <= '0;
          end
        end
      end
      if (cmd_i.out_done && sts_o.last_group) begin
        fill_q <= '0;
        lit_q  <= '0;
        run_q  <= '0;
        fin_q  <= end_q;
      end
    end
  end

  // row buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) byte_q <= body_byte_i;
    if (cmd_i.fill) buf_mem[fill_q[BufAw-1:0]] <= byte_q;
    if (cmd_i.rd) begin
      rdata_q <= buf_mem[addr_q];
      zero_q  <= (10'(addr_q) >= fill_q);
    end
  end

  // group assembly
  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      grp_q  <= '0;
      pl_q   <= '0;
      addr_q <= '0;
      acc_q  <= '0;
    end
    if (cmd_i.acc) begin
      for (int k = 0; k < 8; k++) begin
        if (4'(k) < cnt) acc_q[8*k + 32'(pl_q)] <= rdata_q[7-k] & !zero_q;
      end
      if (sts_o.more_planes) begin
        pl_q   <= pl_q + 3'd1;
        addr_q <= addr_q + BufAw'(stride);
      end
    end
    if (cmd_i.out_done && !sts_o.last_group) begin
      grp_q  <= grp_q + 6'd1;
      pl_q   <= '0;
      addr_q <= BufAw'(grp_q) + BufAw'(1);
      acc_q  <= '0;
    end
  end

  assign pixel_group_o = acc_q;
  assign group_count_o = cnt;
  assign row_end_o     = sts_o.last_group;
  assign image_end_o   = sts_o.last_group && end_q;

  always_comb begin
    case (cfg_idx_i)
      RegWidth:  cfg_rdata_o = 32'(width_q);
      RegHeight: cfg_rdata_o = 32'(height_q);
      RegPlanes: cfg_rdata_o = 32'(planes_q);
      RegComp:   cfg_rdata_o = 32'(comp_q);
      default:   cfg_rdata_o = '0;
    endcase
  end

  `ILBM_ASSERT(a_fill_in_row, clk_i, rst_ni, fill_q <= row_len)
  `ILBM_ASSERT(a_write_in_row, clk_i, rst_ni, cmd_i.fill |-> (fill_q < row_len))
  `ILBM_ASSERT(a_quiet_after_fin, clk_i, rst_ni, fin_q |-> !sts_o.emit_need)

endmodule

`default_nettype wire

// ===== rtl/ilbm_body_planar_decoder_core.sv =====
// ----------------------------------------------------------------------------
// ilbm_body_planar_decoder_core
// interleaved-bitmap body decoder: byterun1 unpacking and planar to chunky
// ----------------------------------------------------------------------------
// Body bytes enter one per input transfer. With compressed set they are
// unpacked as ByteRun1 (0x00..0x7f literal of n+1 bytes, 0x81..0xff run of
// 257-n copies, 0x80 skipped, literals and runs clipped at the row end) into a
// 512-byte planar row buffer holding plane_count planes of word-aligned
// stride. A full row is drained as groups of up to eight 8-bit pixel
// indices, one output transfer each, row_end on the last group of a row and
// image_end on the last group of the image or of a body cut short (missing
// bytes read as zero). After the end every byte is swallowed until a register
// write, which also restarts the body. Bytes are stored through the single
// write port of the row buffer, one byte per write; a row is drained through
// the one read port, one plane byte per read, and output stalls hold the
// drain. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ilbm_body_planar_decoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // apb configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // body byte input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  body_byte_i,
  input  wire logic        last_byte_i,
  // pixel group output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      pixel_group_o,
  output logic [3:0]       group_count_o,
  output logic             row_end_o,
  output logic             image_end_o
);
  import ilbm_pkg::*;

  ilbm_cmd_t cmd;
  ilbm_sts_t sts;
  logic      cfg_we;

  // register write on the access phase, never wait states
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // sequencer
  ilbm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // decode state, row buffer and group assembly
  ilbm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (paddr[3:2]),
    .cfg_wdata_i   (pwdata),
    .cfg_rdata_o   (prdata),
    .body_byte_i   (body_byte_i),
    .last_byte_i   (last_byte_i),
    .pixel_group_o (pixel_group_o),
    .group_count_o (group_count_o),
    .row_end_o     (row_end_o),
    .image_end_o   (image_end_o)
  );

endmodule

`default_nettype wire
